// ===== hdl/trsm_pkg.sv =====
// Shared types and codes for the transmit ring span manager.
// No dependencies; used by tx_ring_span_manager.
`timescale 1ns / 1ps
`default_nettype none

package trsm_pkg;

   // Request kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_SERVICE = 2'd1;
   localparam logic [1:0] KIND_DISCARD = 2'd2;
   localparam logic [1:0] KIND_READ    = 2'd3;

   // Longest span handed to the sink in one go
   localparam int unsigned SPAN_CAP = 65535;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [10:0] message_length;
      logic [9:0]  read_index;
      logic        link_suspended;
      logic        sink_present;
      logic        sink_busy;
      logic        sink_accepts;
   } req_payload_type;

   typedef struct packed {
      logic        accepted;
      logic        start_transfer;
      logic [9:0]  span_start;
      logic [10:0] span_length;
      logic [10:0] buffered_count;
      logic        discard_waiting;
      logic [7:0]  read_data;
   } rsp_payload_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/trsm_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per beat.
// Payload type is supplied by the instantiating scope (see trsm_pkg).
`timescale 1ns / 1ps
`default_nettype none

interface trsm_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/trsm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the transmit ring storage.
`timescale 1ns / 1ps
`default_nettype none

module trsm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tx_ring_span_manager.sv =====
// Transmit byte ring with contiguous span hand-off to a sink.
// Result beat is registered from the request beat; a ring read passes the ring
// RAM read register, then the result register. Throughput: one request beat per
// cycle unless the result is stalled; a ring read holds off the next beat meanwhile.
// Reset: synchronous; clears pointers, counts and flags. Ring contents stay
// undefined until written; no clearing pass is run.
// Depends on trsm_pkg, trsm_stream_if and trsm_ram.
`timescale 1ns / 1ps
`default_nettype none

module tx_ring_span_manager #(
   parameter int RING_BYTES = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   trsm_stream_if.sink   req_bus,
   trsm_stream_if.source rsp_bus
);

   localparam int IW = $clog2(RING_BYTES);
   localparam int CW = $clog2(RING_BYTES + 1);
   localparam int SW = CW + 1;
   localparam int MW = (CW > 11) ? CW : 11;

   // ---------------------------------------------------------------------
   // State registers
   // ---------------------------------------------------------------------
   trsm_pkg::state_type state_ff, state_in;

   logic [IW-1:0] oldest_ff,   oldest_in;
   logic [IW-1:0] wr_idx_ff,   wr_idx_in;
   logic [IW-1:0] cursor_ff,   cursor_in;
   logic [CW-1:0] held_ff,     held_in;
   logic [CW-1:0] inflight_ff, inflight_in;
   logic          discard_ff,  discard_in;
   logic          msg_ok_ff,   msg_ok_in;
   logic [10:0]   room_ff,     room_in;
   logic [10:0]   written_ff,  written_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   trsm_pkg::rsp_payload_type rsp_ff, rsp_in;

   trsm_pkg::req_payload_type req;
   logic                      req_beat;

   logic          ram_wr_en;
   logic [IW-1:0] ram_wr_addr;
   logic          ram_rd_en;
   logic [IW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   assign req = req_bus.payload;

   // Fold a 10-bit read index into the ring by shifted compare-subtract
   function automatic logic [IW-1:0] ring_fold(input logic [9:0] idx);
      logic [9:0] r;
      int         step;
      r = idx;
      for (int k = 5; k >= 0; k--) begin
         step = RING_BYTES << k;
         if (step <= 1023 && {22'd0, r} >= step) begin
            r = r - 10'(step);
         end
      end
      return IW'(r);
   endfunction

   // ---------------------------------------------------------------------
   // Handshake control
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      case (state_ff)
         trsm_pkg::ST_IDLE: begin
            req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
            if (req_bus.valid && req_bus.ready && req.kind == trsm_pkg::KIND_READ) begin
               state_in = trsm_pkg::ST_READ;
            end
         end
         trsm_pkg::ST_READ: begin
            state_in = trsm_pkg::ST_IDLE;
         end
         default: begin
            state_in = trsm_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_beat = req_bus.valid && req_bus.ready;

   // ---------------------------------------------------------------------
   // Pointer update and service step
   // ---------------------------------------------------------------------
   always_comb begin
      logic          ok;
      logic          live;
      logic [IW-1:0] cur;
      logic [10:0]   room;
      logic [10:0]   wrt;
      logic [CW-1:0] held_c;
      logic [CW-1:0] space_c;
      logic          do_service;
      logic          blocked;
      logic [SW-1:0] sum;
      logic [CW-1:0] span;
      logic          start;
      logic [IW-1:0] sst;

      oldest_in   = oldest_ff;
      wr_idx_in   = wr_idx_ff;
      cursor_in   = cursor_ff;
      held_in     = held_ff;
      inflight_in = inflight_ff;
      discard_in  = discard_ff;
      msg_ok_in   = msg_ok_ff;
      room_in     = room_ff;
      written_in  = written_ff;

      ok         = msg_ok_ff;
      live       = 1'b0;
      cur        = cursor_ff;
      room       = room_ff;
      wrt        = written_ff;
      held_c     = held_ff;
      space_c    = CW'(RING_BYTES) - held_ff;
      do_service = 1'b0;
      blocked    = 1'b0;
      sum        = '0;
      span       = '0;
      start      = 1'b0;
      sst        = '0;

      ram_wr_en   = 1'b0;
      ram_wr_addr = cursor_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ring_fold(req.read_index);

      rsp_in = rsp_ff;

      if (req_beat) begin
         case (req.kind)
            trsm_pkg::KIND_BYTE: begin
               // judge a new message on its first byte
               if (req.first_byte) begin
                  ok = !req.link_suspended && !discard_ff && req.message_length != 11'd0
                     && MW'(req.message_length) <= MW'(space_c);
                  if (ok) begin
                     cur  = wr_idx_ff;
                     room = req.message_length;
                     wrt  = 11'd0;
                  end
               end
               // byte is acknowledged whenever its message is live
               live = ok;
               if (ok) begin
                  if (room != 11'd0) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cur;
                     cur  = (cur == IW'(RING_BYTES - 1)) ? '0 : cur + 1'b1;
                     room = room - 11'd1;
                     wrt  = wrt + 11'd1;
                  end
                  // commit on the last byte
                  if (req.last_byte) begin
                     wr_idx_in  = cur;
                     held_c     = held_ff + CW'(wrt);
                     held_in    = held_c;
                     ok         = 1'b0;
                     room       = 11'd0;
                     wrt        = 11'd0;
                     do_service = 1'b1;
                  end
               end
               msg_ok_in  = ok;
               cursor_in  = cur;
               room_in    = room;
               written_in = wrt;
            end
            trsm_pkg::KIND_SERVICE: begin
               do_service = 1'b1;
            end
            trsm_pkg::KIND_DISCARD: begin
               msg_ok_in  = 1'b0;
               room_in    = 11'd0;
               written_in = 11'd0;
               if (req.sink_present && req.sink_busy) begin
                  discard_in = 1'b1;
               end else begin
                  oldest_in   = '0;
                  wr_idx_in   = '0;
                  cursor_in   = '0;
                  held_in     = '0;
                  inflight_in = '0;
                  discard_in  = 1'b0;
               end
            end
            trsm_pkg::KIND_READ: begin
               ram_rd_en = 1'b1;
            end
            default: begin
               ram_rd_en = 1'b0;
            end
         endcase

         // service step: finish a pending discard, or retire released span, then offer the next one
         if (do_service && !req.link_suspended) begin
            if (discard_ff) begin
               if (!(req.sink_present && req.sink_busy)) begin
                  oldest_in   = '0;
                  wr_idx_in   = '0;
                  cursor_in   = '0;
                  held_in     = '0;
                  inflight_in = '0;
                  discard_in  = 1'b0;
               end
            end else begin
               if (inflight_ff != '0) begin
                  if (req.sink_present && !req.sink_busy) begin
                     sum = SW'(oldest_ff) + SW'(inflight_ff);
                     if (sum >= SW'(RING_BYTES)) begin
                        sum = sum - SW'(RING_BYTES);
                     end
                     oldest_in   = IW'(sum);
                     held_c      = (held_c >= inflight_ff) ? held_c - inflight_ff : '0;
                     held_in     = held_c;
                     inflight_in = '0;
                  end else begin
                     blocked = 1'b1;
                  end
               end
               if (!blocked && held_c != '0) begin
                  span = CW'(RING_BYTES) - CW'(oldest_in);
                  if (span > held_c) begin
                     span = held_c;
                  end
                  if (32'(span) > trsm_pkg::SPAN_CAP) begin
                     span = CW'(trsm_pkg::SPAN_CAP);
                  end
                  if (req.sink_present && req.sink_accepts) begin
                     inflight_in = span;
                     start       = 1'b1;
                     sst         = oldest_in;
                  end
               end
            end
         end

         // result beat
         rsp_in.accepted        = live;
         rsp_in.start_transfer  = start;
         rsp_in.span_start      = start ? 10'(sst) : 10'd0;
         rsp_in.span_length     = start ? 11'(span) : 11'd0;
         rsp_in.buffered_count  = 11'(held_in);
         rsp_in.discard_waiting = discard_in;
         rsp_in.read_data       = 8'd0;
      end else if (state_ff == trsm_pkg::ST_READ) begin
         rsp_in.read_data = ram_rd_data;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_beat && req.kind != trsm_pkg::KIND_READ) begin
         rsp_valid_in = 1'b1;
      end
      if (state_ff == trsm_pkg::ST_READ) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trsm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         oldest_ff    <= '0;
         wr_idx_ff    <= '0;
         cursor_ff    <= '0;
         held_ff      <= '0;
         inflight_ff  <= '0;
         discard_ff   <= 1'b0;
         msg_ok_ff    <= 1'b0;
         room_ff      <= '0;
         written_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         oldest_ff    <= oldest_in;
         wr_idx_ff    <= wr_idx_in;
         cursor_ff    <= cursor_in;
         held_ff      <= held_in;
         inflight_ff  <= inflight_in;
         discard_ff   <= discard_in;
         msg_ok_ff    <= msg_ok_in;
         room_ff      <= room_in;
         written_ff   <= written_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // ---------------------------------------------------------------------
   // Ring storage
   // ---------------------------------------------------------------------
   trsm_ram #(
      .WIDTH (8),
      .DEPTH (RING_BYTES),
      .ADDR_W(IW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req.data_byte),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

endmodule

`default_nettype wire
